### hw/rtl/msbb_pkg.sv
`timescale 1ns / 1ps

package msbb_pkg;

    localparam int FIELD_BITS = 32;

    localparam logic [2:0] CMD_GET     = 3'd0;
    localparam logic [2:0] CMD_PUT     = 3'd1;
    localparam logic [2:0] CMD_PUT_BIT = 3'd2;
    localparam logic [2:0] CMD_SKIP    = 3'd3;
    localparam logic [2:0] CMD_REWIND  = 3'd4;

    localparam logic [1:0] CFG_WINDOW_START  = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;

    localparam logic [11:0] WIN_LEN_RESET = 12'd2048;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_REDUCE,
        ST_BYTES,
        ST_ALIGN,
        ST_FINISH
    } msbb_state_t;

endpackage

### hw/rtl/msb_first_bit_buffer.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields (tdata, low bit up)
// s_axis    in   command[2:0], bit_count[14:3], write_value[46:15], zero pad [47]
// m_axis    out  read_value[31:0], bits_moved[43:32], at_end[44], zero pad [47:45]
// cfg       in   cfg_we, cfg_index (0 window_start_bit, 1 window_length_bits), cfg_data
//
// Skip, rewind, unknown commands and zero-length moves pass through setup and finish only.
// Get/put pass through setup, reduce (k = modulo steps on the start byte address), bytes
// (nb = bytes touched, 1..5), align (get only) and finish; one byte per cycle through
// the byte-wide store with registered read.
// After reset the store is swept to zero, byte by byte, with s_axis_tready low.
// A finished result waits in the output register while the next transaction is taken.

module msb_first_bit_buffer #(
    parameter int STORE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // command, bit_count, write_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // read_value, bits_moved, at_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int          AW      = $clog2(STORE_BYTES);
    localparam int unsigned SB      = STORE_BYTES;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    msbb_pkg::msbb_state_t state_reg, state_next;

    logic [10:0] win_start_reg;
    logic [11:0] win_len_reg;
    logic [11:0] cursor_reg, cursor_next;

    logic [2:0]  cmd_reg, cmd_next;
    logic [11:0] count_reg, count_next;
    logic [31:0] value_reg, value_next;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [5:0]  n_reg, n_next;
    logic [11:0] moved_reg, moved_next;
    logic [31:0] vl_reg, vl_next;
    logic [31:0] m32_reg, m32_next;
    logic [2:0]  off_reg, off_next;
    logic [9:0]  byte_reg, byte_next;
    logic [9:0]  wr_byte_reg, wr_byte_next;
    logic [2:0]  nb_reg, nb_next;
    logic [5:0]  lsh_reg, lsh_next;
    logic [39:0] wd_reg, wd_next;
    logic [39:0] wm_reg, wm_next;
    logic [39:0] acc_reg, acc_next;
    logic [31:0] res_reg, res_next;
    logic [2:0]  rd_cnt_reg, rd_cnt_next;
    logic [2:0]  done_cnt_reg, done_cnt_next;
    logic        pend_reg, pend_next;

    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // setup arithmetic
    logic        is_field;
    logic [11:0] room;
    logic [5:0]  n_c;
    logic [31:0] val_c;
    logic [5:0]  mv_field;
    logic [11:0] moved_c;
    logic [12:0] base;
    logic [5:0]  span;
    logic        byte_wrap;
    logic [9:0]  byte_inc;
    logic [9:0]  wr_byte_inc;
    logic        issue;
    logic [39:0] t40;
    logic        out_free;

    assign is_field = (cmd_reg == msbb_pkg::CMD_GET) || (cmd_reg == msbb_pkg::CMD_PUT)
                   || (cmd_reg == msbb_pkg::CMD_PUT_BIT);
    assign room  = (cursor_reg >= win_len_reg) ? 12'd0 : (win_len_reg - cursor_reg);
    assign n_c   = (cmd_reg == msbb_pkg::CMD_PUT_BIT) ? 6'd1
                 : ((count_reg > 12'(msbb_pkg::FIELD_BITS)) ? 6'(msbb_pkg::FIELD_BITS)
                                                           : count_reg[5:0]);
    assign val_c = (cmd_reg == msbb_pkg::CMD_PUT_BIT) ? {31'd0, |value_reg} : value_reg;
    assign mv_field = (12'(n_c) < room) ? n_c : room[5:0];
    assign base  = 13'(win_start_reg) + 13'(cursor_reg);
    assign span  = 6'(base[2:0]) + mv_field + 6'd7;
    assign byte_wrap   = 32'(byte_reg) >= SB;
    assign byte_inc    = ((32'(byte_reg) + 32'd1) == SB) ? 10'd0 : (byte_reg + 10'd1);
    assign wr_byte_inc = ((32'(wr_byte_reg) + 32'd1) == SB) ? 10'd0 : (wr_byte_reg + 10'd1);
    assign issue    = rd_cnt_reg < nb_reg;
    assign t40      = acc_reg << lsh_reg;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        case (cmd_reg)
            msbb_pkg::CMD_GET, msbb_pkg::CMD_PUT, msbb_pkg::CMD_PUT_BIT:
                moved_c = 12'(mv_field);
            msbb_pkg::CMD_SKIP:
                moved_c = (count_reg < room) ? count_reg : room;
            default:
                moved_c = 12'd0;
        endcase
    end

    msbb_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msbb_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = msbb_pkg::ST_IDLE;
                end
            end
            msbb_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = msbb_pkg::ST_SETUP;
                end
            end
            msbb_pkg::ST_SETUP:
            begin
                if (is_field && (mv_field != 6'd0))
                begin
                    state_next = msbb_pkg::ST_REDUCE;
                end
                else
                begin
                    state_next = msbb_pkg::ST_FINISH;
                end
            end
            msbb_pkg::ST_REDUCE:
            begin
                if (!byte_wrap)
                begin
                    state_next = msbb_pkg::ST_BYTES;
                end
            end
            msbb_pkg::ST_BYTES:
            begin
                if (pend_reg && (done_cnt_reg == nb_reg - 3'd1))
                begin
                    state_next = (cmd_reg == msbb_pkg::CMD_GET) ? msbb_pkg::ST_ALIGN
                                                                : msbb_pkg::ST_FINISH;
                end
            end
            msbb_pkg::ST_ALIGN:
            begin
                state_next = msbb_pkg::ST_FINISH;
            end
            msbb_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = msbb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msbb_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        value_next    = value_reg;
        cursor_next   = cursor_reg;
        clr_addr_next = clr_addr_reg;
        n_next        = n_reg;
        moved_next    = moved_reg;
        vl_next       = vl_reg;
        m32_next      = m32_reg;
        off_next      = off_reg;
        byte_next     = byte_reg;
        wr_byte_next  = wr_byte_reg;
        nb_next       = nb_reg;
        lsh_next      = lsh_reg;
        wd_next       = wd_reg;
        wm_next       = wm_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        rd_cnt_next   = rd_cnt_reg;
        done_cnt_next = done_cnt_reg;
        pend_next     = 1'b0;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(wr_byte_reg);
        ram_wdata     = (ram_rdata & ~wm_reg[39:32]) | (wd_reg[39:32] & wm_reg[39:32]);
        ram_raddr     = AW'(byte_reg);

        case (state_reg)
            msbb_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            msbb_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd_next      = s_axis_tdata[2:0];
                count_next    = s_axis_tdata[14:3];
                value_next    = s_axis_tdata[46:15];
            end
            msbb_pkg::ST_SETUP:
            begin
                n_next        = n_c;
                moved_next    = moved_c;
                vl_next       = val_c << (6'd32 - n_c);
                m32_next      = ~(32'hFFFF_FFFF >> mv_field);
                off_next      = base[2:0];
                byte_next     = base[12:3];
                nb_next       = span[5:3];
                lsh_next      = 6'd40 - {span[5:3], 3'b000} + 6'(base[2:0]);
                acc_next      = 40'd0;
                res_next      = 32'd0;
                rd_cnt_next   = 3'd0;
                done_cnt_next = 3'd0;
                if (cmd_reg == msbb_pkg::CMD_REWIND)
                begin
                    cursor_next = 12'd0;
                end
                else
                begin
                    cursor_next = cursor_reg + moved_c;
                end
            end
            msbb_pkg::ST_REDUCE:
            begin
                wd_next = {vl_reg, 8'd0} >> off_reg;
                wm_next = {m32_reg, 8'd0} >> off_reg;
                if (byte_wrap)
                begin
                    byte_next = byte_reg - 10'(STORE_BYTES);
                end
                else
                begin
                    wr_byte_next = byte_reg;
                end
            end
            msbb_pkg::ST_BYTES:
            begin
                if (issue)
                begin
                    byte_next   = byte_inc;
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    done_cnt_next = done_cnt_reg + 3'd1;
                    if (cmd_reg == msbb_pkg::CMD_GET)
                    begin
                        acc_next = {acc_reg[31:0], ram_rdata};
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        wd_next      = wd_reg << 8;
                        wm_next      = wm_reg << 8;
                        wr_byte_next = wr_byte_inc;
                    end
                end
            end
            msbb_pkg::ST_ALIGN:
            begin
                res_next = (t40[39:8] & m32_reg) >> (6'd32 - n_reg);
            end
            msbb_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'd0, (cursor_reg >= win_len_reg), moved_reg, res_reg};
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msbb_pkg::ST_CLEAR;
            win_start_reg <= 11'd0;
            win_len_reg   <= msbb_pkg::WIN_LEN_RESET;
            cursor_reg    <= 12'd0;
            clr_addr_reg  <= '0;
            rd_cnt_reg    <= 3'd0;
            done_cnt_reg  <= 3'd0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            clr_addr_reg <= clr_addr_next;
            rd_cnt_reg   <= rd_cnt_next;
            done_cnt_reg <= done_cnt_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we && (cfg_index == msbb_pkg::CFG_WINDOW_START))
            begin
                win_start_reg <= cfg_data[10:0];
            end
            if (cfg_we && (cfg_index == msbb_pkg::CFG_WINDOW_LENGTH))
            begin
                win_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        count_reg   <= count_next;
        value_reg   <= value_next;
        n_reg       <= n_next;
        moved_reg   <= moved_next;
        vl_reg      <= vl_next;
        m32_reg     <= m32_next;
        off_reg     <= off_next;
        byte_reg    <= byte_next;
        wr_byte_reg <= wr_byte_next;
        nb_reg      <= nb_next;
        lsh_reg     <= lsh_next;
        wd_reg      <= wd_next;
        wm_reg      <= wm_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

endmodule

### hw/rtl/msbb_ram.sv
`timescale 1ns / 1ps

module msbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### bench/msb_first_bit_buffer_tb.sv
`timescale 1ns / 1ps

module msb_first_bit_buffer_tb;

    localparam int STORE_BYTES   = 256;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 200;

    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam logic [1:0] CFG_RSVD_2 = 2'd2;
    localparam logic [1:0] CFG_RSVD_3 = 2'd3;

    typedef struct packed {
        logic [31:0] read_value;
        logic [11:0] bits_moved;
        logic        at_end;
    } bit_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // command, bit_count, write_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // read_value, bits_moved, at_end
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [11:0] cfg_data      = '0;

    // handshake state sampled mid-cycle, used at the next rising edge
    logic        s_fire = 1'b0;
    logic        m_fire = 1'b0;
    logic [47:0] m_word = '0;

    logic [7:0]  store_img [STORE_BYTES];
    logic [11:0] cursor_pos;
    logic [10:0] win_start;
    logic [11:0] win_len;

    bit_result_t pending_results [$];
    int          errors     = 0;
    int          idle_count = 0;
    int          burst_left = 0;

    int          stall_mode = 0;
    int          stall_left = 0;
    int          stall_tick = 0;

    msb_first_bit_buffer #(
        .STORE_BYTES(STORE_BYTES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        s_fire <= (s_axis_tvalid === 1'b1) && (s_axis_tready === 1'b1);
        m_fire <= (m_axis_tvalid === 1'b1) && (m_axis_tready === 1'b1);
        m_word <= m_axis_tdata;
    end

    // ------------------------------------------------------------------
    // Bit store predictor
    // ------------------------------------------------------------------
    function automatic logic store_bit(input int addr);
        int idx;
        idx = (addr >> 3) % STORE_BYTES;
        return store_img[idx][7 - (addr & 7)];
    endfunction

    function automatic void write_store_bit(input int addr, input logic b);
        int idx;
        idx = (addr >> 3) % STORE_BYTES;
        store_img[idx][7 - (addr & 7)] = b;
    endfunction

    function automatic bit_result_t apply_bit_command(input logic [2:0] cmd,
                                                      input logic [11:0] count,
                                                      input logic [31:0] value);
        bit_result_t res;
        int          room;
        int          n;
        int          moved;
        int          base;
        logic [31:0] rv;
        room  = (cursor_pos >= win_len) ? 0 : int'(win_len) - int'(cursor_pos);
        base  = int'(win_start) + int'(cursor_pos);
        n     = (int'(count) > msbb_pkg::FIELD_BITS) ? msbb_pkg::FIELD_BITS : int'(count);
        rv    = '0;
        moved = 0;
        case (cmd)
            msbb_pkg::CMD_GET:
            begin
                moved = (n < room) ? n : room;
                for (int i = 0; i < moved; i++)
                    rv = {rv[30:0], store_bit(base + i)};
                if (n > moved)
                    rv = rv << (n - moved);
                cursor_pos = cursor_pos + 12'(moved);
            end
            msbb_pkg::CMD_PUT:
            begin
                moved = (n < room) ? n : room;
                for (int i = 0; i < moved; i++)
                    write_store_bit(base + i, value[n - 1 - i]);
                cursor_pos = cursor_pos + 12'(moved);
            end
            msbb_pkg::CMD_PUT_BIT:
            begin
                if (room > 0)
                begin
                    write_store_bit(base, value != 0);
                    moved      = 1;
                    cursor_pos = cursor_pos + 12'd1;
                end
            end
            msbb_pkg::CMD_SKIP:
            begin
                moved      = (int'(count) < room) ? int'(count) : room;
                cursor_pos = cursor_pos + 12'(moved);
            end
            msbb_pkg::CMD_REWIND:
                cursor_pos = '0;
            default:
                ;
        endcase
        res.read_value = rv;
        res.bits_moved = 12'(moved);
        res.at_end     = (cursor_pos >= win_len);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin : check_results
        bit_result_t want;
        if (m_fire)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", m_word[31:0], 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_word[31:0] !== want.read_value)
                    report_mismatch("read_value", m_word[31:0], want.read_value);
                if (m_word[43:32] !== want.bits_moved)
                    report_mismatch("bits_moved", 32'(m_word[43:32]), 32'(want.bits_moved));
                if (m_word[44] !== want.at_end)
                    report_mismatch("at_end", 32'(m_word[44]), 32'(want.at_end));
                if (m_word[47:45] !== 3'b000)
                    report_mismatch("pad", 32'(m_word[47:45]), 32'd0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (s_fire || m_fire)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_MAX)
        begin
            $display("FAIL msb_first_bit_buffer");
            $finish;
        end
    end

    // receiver stalls: always ready, coin flip, periodic, mostly stalled
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= (stall_tick % 3) != 0;
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] cmd, input logic [11:0] count,
                             input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value, count, cmd};
        @(posedge clk);
        while (!s_fire)
            @(posedge clk);
        pending_results.push_back(apply_bit_command(cmd, count, value));
    endtask

    task automatic drain_results();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [11:0] start_bits, input logic [11:0] len_bits,
                                input bit junk);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= msbb_pkg::CFG_WINDOW_START;
        cfg_data  <= start_bits;
        @(posedge clk);
        win_start = start_bits[10:0];
        cfg_index <= msbb_pkg::CFG_WINDOW_LENGTH;
        cfg_data  <= len_bits;
        @(posedge clk);
        win_len = len_bits;
        if (junk)
        begin
            cfg_index <= CFG_RSVD_2;
            cfg_data  <= 12'($urandom());
            @(posedge clk);
            cfg_index <= CFG_RSVD_3;
            cfg_data  <= 12'($urandom());
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [11:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 12'($urandom_range(33, 4095));
            1:       return 12'd0;
            2:       return 12'd32;
            default: return 12'($urandom_range(1, 32));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_commands();
        send_item(msbb_pkg::CMD_GET, 12'd32, 32'hFFFF_FFFF);
        send_item(msbb_pkg::CMD_PUT, 12'd32, 32'hFFFF_FFFF);
        send_item(msbb_pkg::CMD_PUT, 12'd0, 32'hFFFF_FFFF);
        send_item(msbb_pkg::CMD_PUT, 12'd4095, 32'hA5A5_5A5A);
        send_item(msbb_pkg::CMD_PUT_BIT, 12'd1, 32'h0000_0000);
        send_item(msbb_pkg::CMD_PUT_BIT, 12'd0, 32'h8000_0000);
        send_item(msbb_pkg::CMD_SKIP, 12'd0, 32'h0);
        send_item(msbb_pkg::CMD_REWIND, 12'd4095, 32'hFFFF_FFFF);
        send_item(msbb_pkg::CMD_GET, 12'd0, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd4095, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd33, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd1, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd32, 32'h0);
        send_item(CMD_RSVD_5, 12'd7, 32'h1234_5678);
        send_item(CMD_RSVD_6, 12'd4095, 32'hFFFF_FFFF);
        send_item(CMD_RSVD_7, 12'd32, 32'h0);
        send_item(msbb_pkg::CMD_SKIP, 12'd4095, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd32, 32'h0);
        send_item(msbb_pkg::CMD_PUT, 12'd32, 32'h5555_AAAA);
        send_item(msbb_pkg::CMD_PUT_BIT, 12'd1, 32'h1);
        send_item(msbb_pkg::CMD_REWIND, 12'd0, 32'h0);
    endtask

    task automatic test_window_edges();
        // window straddling the top of the store
        write_window(12'd2044, 12'd12, 1'b0);
        send_item(msbb_pkg::CMD_PUT, 12'd12, 32'h0000_0ABC);
        send_item(msbb_pkg::CMD_REWIND, 12'd0, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd12, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd5, 32'h0);
        send_item(msbb_pkg::CMD_REWIND, 12'd0, 32'h0);
        send_item(msbb_pkg::CMD_SKIP, 12'd7, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd32, 32'h0);
        // window shrunk below the cursor
        write_window(12'd0, 12'd2048, 1'b0);
        send_item(msbb_pkg::CMD_SKIP, 12'd100, 32'h0);
        write_window(12'd0, 12'd50, 1'b0);
        send_item(msbb_pkg::CMD_GET, 12'd8, 32'h0);
        send_item(msbb_pkg::CMD_PUT_BIT, 12'd1, 32'h1);
        send_item(msbb_pkg::CMD_SKIP, 12'd3, 32'h0);
        send_item(CMD_RSVD_7, 12'd3, 32'h0);
        send_item(msbb_pkg::CMD_REWIND, 12'd0, 32'h0);
        send_item(msbb_pkg::CMD_GET, 12'd8, 32'h0);
        // empty window, start written with its unused top bit set
        write_window(12'hFFF, 12'd0, 1'b1);
        send_item(msbb_pkg::CMD_GET, 12'd32, 32'h0);
        send_item(msbb_pkg::CMD_PUT, 12'd32, 32'hFFFF_FFFF);
        send_item(msbb_pkg::CMD_PUT_BIT, 12'd1, 32'h1);
        send_item(msbb_pkg::CMD_REWIND, 12'd0, 32'h0);
        write_window(12'd0, 12'd2048, 1'b1);
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          nput;
        int          nnoise;
        bit          paused;
        logic [2:0]  ops [8];
        logic [11:0] counts [8];
        paused = 1'b0;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: write_window(12'd0, 12'd2048, 1'b0);
                1: write_window(12'd2047, 12'd2048, 1'b0);
                2: write_window(12'($urandom_range(0, 2047)), 12'($urandom_range(1, 64)), 1'b0);
                3: write_window(12'($urandom_range(0, 2047)), 12'($urandom_range(0, 2048)),
                                1'b1);
                4: write_window(12'($urandom_range(0, 2047)), 12'd0, 1'b0);
                5: write_window(12'($urandom_range(0, 2047)), 12'($urandom_range(100, 2048)),
                                1'b0);
                default: write_window(12'd2047, 12'd1, 1'b0);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    // write a run of fields, then read them back
                    nput = $urandom_range(1, 8);
                    send_item(msbb_pkg::CMD_REWIND, pick_count(), $urandom());
                    for (int k = 0; k < nput; k++)
                    begin
                        ops[k]    = ($urandom_range(0, 5) == 0) ? msbb_pkg::CMD_PUT_BIT
                                                                : msbb_pkg::CMD_PUT;
                        counts[k] = (ops[k] == msbb_pkg::CMD_PUT_BIT) ? 12'd1 : pick_count();
                        send_item(ops[k], counts[k],
                                  ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom());
                    end
                    send_item(msbb_pkg::CMD_REWIND, pick_count(), $urandom());
                    for (int k = 0; k < nput; k++)
                        send_item(msbb_pkg::CMD_GET, counts[k], $urandom());
                    sent += 2 + 2 * nput;
                end
                else
                begin
                    nnoise = $urandom_range(1, 6);
                    for (int k = 0; k < nnoise; k++)
                        send_item(3'($urandom_range(0, 7)), 12'($urandom()), $urandom());
                    sent += nnoise;
                end
                if (phase == 2 && sent >= PHASE_ITEMS / 2 && !paused)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial
    begin
        foreach (store_img[i])
            store_img[i] = 8'h00;
        cursor_pos = '0;
        win_start  = '0;
        win_len    = msbb_pkg::WIN_LEN_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_window_edges();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS msb_first_bit_buffer");
        else
            $display("FAIL msb_first_bit_buffer");
        $finish;
    end

endmodule
